// ===== design/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Circle-box contact package
// Constants shared by the circle versus axis-aligned box contact unit.
// ----------------------------------------------------------------------------
package cbc_pkg;

  // Full box extents are halved by a right shift of this many bits.
  localparam int unsigned HalfShift = 1;

endpackage

// ===== design/circle_box_contact_unit.sv =====
// ----------------------------------------------------------------------------
// One transfer is taken in every cycle and busy_o stays low.
// The square root takes one pipeline stage per result bit.
// Each normal division takes one stage per quotient bit.
// Reset clears only the valid bits, so no stale result is reported after reset.
// ----------------------------------------------------------------------------
// Circle versus axis-aligned box contact unit
// Clamps the circle center to the box, then derives hit, normal, depth and
// contact points in a fully pipelined datapath.
// ----------------------------------------------------------------------------
module circle_box_contact_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] circle_center_x_i,
  input  logic signed [COORD_WIDTH-1:0] circle_center_z_i,
  input  logic        [COORD_WIDTH-2:0] circle_radius_i,
  input  logic signed [COORD_WIDTH-1:0] box_center_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_center_z_i,
  input  logic        [COORD_WIDTH-2:0] box_full_width_i,
  input  logic        [COORD_WIDTH-2:0] box_full_height_i,
  output logic                          result_valid_o,
  output logic                          hit_o,
  output logic signed [FRAC_BITS+1:0]   normal_x_o,
  output logic signed [FRAC_BITS+1:0]   normal_z_o,
  output logic        [COORD_WIDTH-2:0] penetration_depth_o,
  output logic signed [COORD_WIDTH-1:0] world_contact_x_o,
  output logic signed [COORD_WIDTH-1:0] world_contact_z_o,
  output logic signed [COORD_WIDTH-1:0] circle_local_x_o,
  output logic signed [COORD_WIDTH-1:0] circle_local_z_o,
  output logic signed [COORD_WIDTH-1:0] box_local_x_o,
  output logic signed [COORD_WIDTH-1:0] box_local_z_o
);
  import cbc_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int RW = COORD_WIDTH - 1;
  localparam int NW = FRAC_BITS + 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int SW = 2 * RW + 1;
  localparam logic signed [CW:0] SatHi = (CW+1)'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [CW:0] SatLo = -SatHi - (CW+1)'(1);

  typedef struct packed {
    logic              hit;
    logic              sx;
    logic              sz;
    logic [RW-1:0]     rad;
    logic [RW-1:0]     ax;
    logic [RW-1:0]     az;
    logic [CW-1:0]     px;
    logic [CW-1:0]     pz;
    logic [CW-1:0]     wcx;
    logic [CW-1:0]     wcz;
  } ctx_t;

  assign busy_o = 1'b0;

  // Stage 1: relative center and half extents.
  logic                 s1_v_q;
  logic signed [CW:0]   s1_rx_q, s1_rz_q;
  logic signed [CW:0]   s1_hx_q, s1_hz_q;
  logic [RW-1:0]        s1_r_q;
  logic signed [CW-1:0] s1_bx_q, s1_bz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_rx_q <= (CW+1)'(circle_center_x_i) - (CW+1)'(box_center_x_i);
    s1_rz_q <= (CW+1)'(circle_center_z_i) - (CW+1)'(box_center_z_i);
    s1_hx_q <= signed'({2'b00, box_full_width_i >> HalfShift});
    s1_hz_q <= signed'({2'b00, box_full_height_i >> HalfShift});
    s1_r_q  <= circle_radius_i;
    s1_bx_q <= box_center_x_i;
    s1_bz_q <= box_center_z_i;
  end

  // Stage 2: clamp to the box and form the offset.
  logic signed [CW:0] s2_px_d, s2_pz_d;
  logic               s2_v_q;
  logic signed [CW:0] s2_px_q, s2_pz_q, s2_dx_q, s2_dz_q;
  logic [RW-1:0]      s2_r_q;
  logic signed [CW-1:0] s2_bx_q, s2_bz_q;

  always_comb begin
    if (s1_rx_q > s1_hx_q) begin
      s2_px_d = s1_hx_q;
    end else if (s1_rx_q < -s1_hx_q) begin
      s2_px_d = -s1_hx_q;
    end else begin
      s2_px_d = s1_rx_q;
    end
    if (s1_rz_q > s1_hz_q) begin
      s2_pz_d = s1_hz_q;
    end else if (s1_rz_q < -s1_hz_q) begin
      s2_pz_d = -s1_hz_q;
    end else begin
      s2_pz_d = s1_rz_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_px_q <= s2_px_d;
    s2_pz_q <= s2_pz_d;
    s2_dx_q <= s1_rx_q - s2_px_d;
    s2_dz_q <= s1_rz_q - s2_pz_d;
    s2_r_q  <= s1_r_q;
    s2_bx_q <= s1_bx_q;
    s2_bz_q <= s1_bz_q;
  end

  // Stage 3: magnitudes, range check and world contact point.
  logic [CW:0]        s3_adx_d, s3_adz_d;
  logic signed [CW:0] s3_wx_d, s3_wz_d;
  logic               s3_v_q, s3_far_q;
  ctx_t               s3_ctx_q;

  always_comb begin
    s3_adx_d = s2_dx_q[CW] ? unsigned'(-s2_dx_q) : unsigned'(s2_dx_q);
    s3_adz_d = s2_dz_q[CW] ? unsigned'(-s2_dz_q) : unsigned'(s2_dz_q);
    s3_wx_d  = s2_px_q + (CW+1)'(s2_bx_q);
    s3_wz_d  = s2_pz_q + (CW+1)'(s2_bz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_far_q     <= (s3_adx_d > (CW+1)'(s2_r_q)) || (s3_adz_d > (CW+1)'(s2_r_q));
    s3_ctx_q.hit <= 1'b0;
    s3_ctx_q.sx  <= s2_dx_q[CW];
    s3_ctx_q.sz  <= s2_dz_q[CW];
    s3_ctx_q.rad <= s2_r_q;
    s3_ctx_q.ax  <= s3_adx_d[RW-1:0];
    s3_ctx_q.az  <= s3_adz_d[RW-1:0];
    s3_ctx_q.px  <= s2_px_q[CW-1:0];
    s3_ctx_q.pz  <= s2_pz_q[CW-1:0];
    s3_ctx_q.wcx <= (s3_wx_d > SatHi) ? SatHi[CW-1:0] :
                    (s3_wx_d < SatLo) ? SatLo[CW-1:0] : s3_wx_d[CW-1:0];
    s3_ctx_q.wcz <= (s3_wz_d > SatHi) ? SatHi[CW-1:0] :
                    (s3_wz_d < SatLo) ? SatLo[CW-1:0] : s3_wz_d[CW-1:0];
  end

  // Stage 4: squares.
  logic            s4_v_q, s4_far_q;
  logic [2*RW-1:0] s4_sqx_q, s4_sqz_q, s4_rr_q;
  ctx_t            s4_ctx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_sqx_q <= (2*RW)'(s3_ctx_q.ax) * (2*RW)'(s3_ctx_q.ax);
    s4_sqz_q <= (2*RW)'(s3_ctx_q.az) * (2*RW)'(s3_ctx_q.az);
    s4_rr_q  <= (2*RW)'(s3_ctx_q.rad) * (2*RW)'(s3_ctx_q.rad);
    s4_far_q <= s3_far_q;
    s4_ctx_q <= s3_ctx_q;
  end

  // Stage 5 and square root stages: one root bit per stage.
  logic [SW-1:0] s5_sum_d;
  ctx_t          s5_ctx_d;
  logic          sq_v_q   [RW+1];
  logic [SW-1:0] sq_rem_q [RW+1];
  logic [RW-1:0] sq_root_q[RW+1];
  ctx_t          sq_ctx_q [RW+1];

  assign s5_sum_d = SW'(s4_sqx_q) + SW'(s4_sqz_q);

  always_comb begin
    s5_ctx_d     = s4_ctx_q;
    s5_ctx_d.hit = !s4_far_q && (s5_sum_d <= SW'(s4_rr_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else begin
      sq_v_q[0] <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_rem_q[0]  <= s5_sum_d;
    sq_root_q[0] <= '0;
    sq_ctx_q[0]  <= s5_ctx_d;
  end

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    localparam int B = RW - 1 - i;
    logic [SW-1:0] trial;
    logic          take;

    always_comb begin
      trial = (SW'(sq_root_q[i]) << (B + 1)) | (SW'(1) << (2 * B));
      take  = sq_rem_q[i] >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[i+1] <= 1'b0;
      end else begin
        sq_v_q[i+1] <= sq_v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_rem_q[i+1]  <= take ? sq_rem_q[i] - trial : sq_rem_q[i];
      sq_root_q[i+1] <= take ? sq_root_q[i] | (RW'(1) << B) : sq_root_q[i];
      sq_ctx_q[i+1]  <= sq_ctx_q[i];
    end
  end

  // Normal division stages: one quotient bit per stage for both axes.
  logic          dv_v_q   [FRAC_BITS+1];
  logic [RW-1:0] dv_den_q [FRAC_BITS+1];
  logic [RW-1:0] dv_remx_q[FRAC_BITS+1];
  logic [RW-1:0] dv_remz_q[FRAC_BITS+1];
  logic [QW-1:0] dv_qx_q  [FRAC_BITS+1];
  logic [QW-1:0] dv_qz_q  [FRAC_BITS+1];
  ctx_t          dv_ctx_q [FRAC_BITS+1];
  logic          d0_gex, d0_gez;

  assign d0_gex = sq_ctx_q[RW].ax >= sq_root_q[RW];
  assign d0_gez = sq_ctx_q[RW].az >= sq_root_q[RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else begin
      dv_v_q[0] <= sq_v_q[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_den_q[0]  <= sq_root_q[RW];
    dv_remx_q[0] <= d0_gex ? sq_ctx_q[RW].ax - sq_root_q[RW] : sq_ctx_q[RW].ax;
    dv_remz_q[0] <= d0_gez ? sq_ctx_q[RW].az - sq_root_q[RW] : sq_ctx_q[RW].az;
    dv_qx_q[0]   <= QW'(d0_gex);
    dv_qz_q[0]   <= QW'(d0_gez);
    dv_ctx_q[0]  <= sq_ctx_q[RW];
  end

  for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_div
    logic [RW:0] tx, tz;
    logic        gex, gez;

    always_comb begin
      tx  = {dv_remx_q[j-1], 1'b0};
      tz  = {dv_remz_q[j-1], 1'b0};
      gex = tx >= (RW+1)'(dv_den_q[j-1]);
      gez = tz >= (RW+1)'(dv_den_q[j-1]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j] <= 1'b0;
      end else begin
        dv_v_q[j] <= dv_v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_den_q[j]  <= dv_den_q[j-1];
      dv_remx_q[j] <= gex ? RW'(tx - (RW+1)'(dv_den_q[j-1])) : RW'(tx);
      dv_remz_q[j] <= gez ? RW'(tz - (RW+1)'(dv_den_q[j-1])) : RW'(tz);
      dv_qx_q[j]   <= {dv_qx_q[j-1][QW-2:0], gex};
      dv_qz_q[j]   <= {dv_qz_q[j-1][QW-2:0], gez};
      dv_ctx_q[j]  <= dv_ctx_q[j-1];
    end
  end

  // Multiply stage: circle local magnitudes.
  logic [QW-1:0] mg_nx_d, mg_nz_d;
  logic          mg_v_q;
  logic [QW-1:0] mg_nx_q, mg_nz_q;
  logic [RW-1:0] mg_dist_q;
  logic [QW+RW-1:0] mg_lx_q, mg_lz_q;
  ctx_t          mg_ctx_q;

  always_comb begin
    if (dv_den_q[FRAC_BITS] == '0) begin
      mg_nx_d = '0;
      mg_nz_d = '0;
    end else begin
      mg_nx_d = dv_qx_q[FRAC_BITS];
      mg_nz_d = dv_qz_q[FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mg_v_q <= 1'b0;
    end else begin
      mg_v_q <= dv_v_q[FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    mg_nx_q   <= mg_nx_d;
    mg_nz_q   <= mg_nz_d;
    mg_dist_q <= dv_den_q[FRAC_BITS];
    mg_lx_q   <= (QW+RW)'(mg_nx_d) * (QW+RW)'(dv_ctx_q[FRAC_BITS].rad);
    mg_lz_q   <= (QW+RW)'(mg_nz_d) * (QW+RW)'(dv_ctx_q[FRAC_BITS].rad);
    mg_ctx_q  <= dv_ctx_q[FRAC_BITS];
  end

  // Output stage: signs and masking of misses.
  logic [CW-1:0] mg_magx, mg_magz;
  logic [NW-1:0] mg_snx, mg_snz;

  always_comb begin
    mg_magx = CW'(mg_lx_q >> FRAC_BITS);
    mg_magz = CW'(mg_lz_q >> FRAC_BITS);
    mg_snx  = mg_ctx_q.sx ? NW'(-NW'(mg_nx_q)) : NW'(mg_nx_q);
    mg_snz  = mg_ctx_q.sz ? NW'(-NW'(mg_nz_q)) : NW'(mg_nz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= mg_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mg_ctx_q.hit) begin
      hit_o               <= 1'b1;
      normal_x_o          <= signed'(mg_snx);
      normal_z_o          <= signed'(mg_snz);
      penetration_depth_o <= mg_ctx_q.rad - mg_dist_q;
      world_contact_x_o   <= signed'(mg_ctx_q.wcx);
      world_contact_z_o   <= signed'(mg_ctx_q.wcz);
      circle_local_x_o    <= signed'(mg_ctx_q.sx ? mg_magx : CW'(-mg_magx));
      circle_local_z_o    <= signed'(mg_ctx_q.sz ? mg_magz : CW'(-mg_magz));
      box_local_x_o       <= signed'(mg_ctx_q.px);
      box_local_z_o       <= signed'(mg_ctx_q.pz);
    end else begin
      hit_o               <= 1'b0;
      normal_x_o          <= '0;
      normal_z_o          <= '0;
      penetration_depth_o <= '0;
      world_contact_x_o   <= '0;
      world_contact_z_o   <= '0;
      circle_local_x_o    <= '0;
      circle_local_z_o    <= '0;
      box_local_x_o       <= '0;
      box_local_z_o       <= '0;
    end
  end

endmodule

// ===== dv/tb_circle_box_contact_unit.sv =====
// ----------------------------------------------------------------------------
// Circle-box contact unit testbench
// Sends circle and box pairs through the unit and compares every result with
// a contact predictor built into the bench, under several idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_circle_box_contact_unit;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int LATENCY = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic                 hit;
    logic signed [FB+1:0] nx;
    logic signed [FB+1:0] nz;
    logic [CW-2:0]        depth;
    logic signed [CW-1:0] wx;
    logic signed [CW-1:0] wz;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cz;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] bz;
  } contact_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [CW-1:0] circle_center_x_i = '0;
  logic signed [CW-1:0] circle_center_z_i = '0;
  logic [CW-2:0] circle_radius_i = '0;
  logic signed [CW-1:0] box_center_x_i = '0;
  logic signed [CW-1:0] box_center_z_i = '0;
  logic [CW-2:0] box_full_width_i = '0;
  logic [CW-2:0] box_full_height_i = '0;
  logic result_valid_o, hit_o;
  logic signed [FB+1:0] normal_x_o, normal_z_o;
  logic [CW-2:0] penetration_depth_o;
  logic signed [CW-1:0] world_contact_x_o, world_contact_z_o;
  logic signed [CW-1:0] circle_local_x_o, circle_local_z_o;
  logic signed [CW-1:0] box_local_x_o, box_local_z_o;

  contact_t expected_contacts[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;

  circle_box_contact_unit DUT (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int b = CW + 1; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (128'(cand) * 128'(cand) <= n) res = cand;
    end
    return res;
  endfunction

  function automatic contact_t predict_contact(logic signed [CW-1:0] ccx,
      logic signed [CW-1:0] ccz, logic [CW-2:0] rad, logic signed [CW-1:0] bcx,
      logic signed [CW-1:0] bcz, logic [CW-2:0] fw, logic [CW-2:0] fh);
    contact_t c;
    longint hx, hz, rx, rz, px, pz, dx, dz, wx, wz, nx, nz, mag;
    longint unsigned adx, adz, root_dist, r, an;
    logic [127:0] s;
    c = '0;
    r = rad;
    hx = longint'(fw >> cbc_pkg::HalfShift);
    hz = longint'(fh >> cbc_pkg::HalfShift);
    rx = longint'(ccx) - longint'(bcx);
    rz = longint'(ccz) - longint'(bcz);
    px = rx > hx ? hx : (rx < -hx ? -hx : rx);
    pz = rz > hz ? hz : (rz < -hz ? -hz : rz);
    dx = rx - px;
    dz = rz - pz;
    adx = dx < 0 ? -dx : dx;
    adz = dz < 0 ? -dz : dz;
    if (adx > r || adz > r) return c;
    s = 128'(adx) * 128'(adx) + 128'(adz) * 128'(adz);
    if (s > 128'(r) * 128'(r)) return c;
    root_dist = isqrt(s);
    nx = root_dist == 0 ? 0 : longint'((128'(adx) << FB) / 128'(root_dist));
    nz = root_dist == 0 ? 0 : longint'((128'(adz) << FB) / 128'(root_dist));
    if (dx < 0) nx = -nx;
    if (dz < 0) nz = -nz;
    wx = px + longint'(bcx);
    wz = pz + longint'(bcz);
    c.hit = 1'b1;
    c.nx = nx[FB+1:0];
    c.nz = nz[FB+1:0];
    c.depth = (CW-1)'(r - root_dist);
    c.wx = wx > 64'sh7FFFFFFF ? 32'h7FFFFFFF : (wx < -64'sh80000000 ? 32'h80000000 : wx[31:0]);
    c.wz = wz > 64'sh7FFFFFFF ? 32'h7FFFFFFF : (wz < -64'sh80000000 ? 32'h80000000 : wz[31:0]);
    an = nx < 0 ? -nx : nx;
    mag = longint'(an * (r >> FB) + ((an * (r & 64'hFFFF)) >> FB));
    c.cx = nx < 0 ? mag[31:0] : -mag[31:0];
    an = nz < 0 ? -nz : nz;
    mag = longint'(an * (r >> FB) + ((an * (r & 64'hFFFF)) >> FB));
    c.cz = nz < 0 ? mag[31:0] : -mag[31:0];
    c.bx = px[31:0];
    c.bz = pz[31:0];
    return c;
  endfunction

  task automatic send_pair(logic signed [CW-1:0] ccx, logic signed [CW-1:0] ccz,
      logic [CW-2:0] rad, logic signed [CW-1:0] bcx, logic signed [CW-1:0] bcz,
      logic [CW-2:0] fw, logic [CW-2:0] fh);
    while ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    circle_center_x_i <= ccx;
    circle_center_z_i <= ccz;
    circle_radius_i <= rad;
    box_center_x_i <= bcx;
    box_center_z_i <= bcz;
    box_full_width_i <= fw;
    box_full_height_i <= fh;
    do @(posedge clk_i); while (busy_o);
    expected_contacts.push_back(predict_contact(ccx, ccz, rad, bcx, bcz, fw, fh));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (expected_contacts.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(400000)) - 200000);
      default: return 32'($signed($urandom_range(8000000)) - 4000000);
    endcase
  endfunction

  function automatic logic [CW-2:0] pick_size();
    case ($urandom_range(3))
      0: return 31'($urandom());
      1: return 31'($urandom_range(20));
      default: return 31'($urandom_range(4000000));
    endcase
  endfunction

  task automatic test_directed();
    logic [CW-2:0] rmax;
    rmax = '1;
    send_pair(0, 0, 0, 0, 0, 0, 0);
    send_pair(100, 100, 50, 0, 0, 400, 400);
    send_pair(32'h10000, 0, 31'h8000, 0, 0, 0, 0);
    send_pair(32'h30000, 0, 31'h10000, 0, 0, 31'h40000, 31'h40000);
    send_pair(32'h30000, 0, 31'hFFFF, 0, 0, 31'h40000, 31'h40000);
    send_pair(-32'h30000, 32'h30000, 31'h20000, 0, 0, 31'h40000, 31'h40000);
    send_pair(3, 4, 5, 0, 0, 0, 0);
    send_pair(-3, -4, 5, 0, 0, 0, 0);
    send_pair(32'h7FFFFFFF, 32'h7FFFFFFF, rmax, 32'h80000000, 32'h80000000, rmax, rmax);
    send_pair(32'h80000000, 32'h80000000, rmax, 32'h7FFFFFFF, 32'h7FFFFFFF, rmax, rmax);
    send_pair(32'h7FFFFFFF, 32'h80000000, rmax, 32'h7FFFFFFF, 32'h80000000, 0, 0);
    send_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, rmax, rmax);
    send_pair(32'h80000000, 32'h7FFFFFFF, rmax, 32'h7FFFFFFF, 32'h80000000, 0, 0);
    send_pair(32'h7FFFFFFF, 32'h80000000, 10, 32'h80000000, 32'h7FFFFFFF, rmax, rmax);
    send_pair(0, 32'h50000, 31'h10000, 0, 0, 31'h100000, 31'h80000);
    send_pair(32'h50000, 32'h50000, rmax, 0, 0, 1, 1);
    drain_results();
  endtask

  task automatic test_random(int count, int idle_pct);
    logic signed [CW-1:0] bcx, bcz, ccx, ccz;
    logic [CW-2:0] fw, fh, rad;
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      bcx = pick_coord();
      bcz = pick_coord();
      fw = pick_size();
      fh = pick_size();
      rad = pick_size();
      if ($urandom_range(3) != 0) begin
        // Place the circle near the box so that most pairs touch or almost touch.
        ccx = bcx + 32'($signed(32'(fw >> 1)) + $signed($urandom_range(2000)) - 1000)
              * ($urandom_range(1) ? 1 : -1);
        ccz = bcz + 32'($signed($urandom_range(32'(fh))) - $signed(32'(fh >> 1)));
        if ($urandom_range(1)) begin
          ccx = ccx ^ ccz;
          ccz = ccx ^ ccz;
          ccx = ccx ^ ccz;
        end
        rad = $urandom_range(1) ? 31'($urandom_range(3000)) : rad;
      end else begin
        ccx = pick_coord();
        ccz = pick_coord();
      end
      send_pair(ccx, ccz, rad, bcx, bcz, fw, fh);
    end
    send_idle_pct = 0;
  endtask

  task automatic test_quiet_pause();
    send_pair(0, 0, 31'h10000, 0, 0, 31'h20000, 31'h20000);
    drain_results();
    send_pair(32'h20000, 32'h20000, 31'h20000, 0, 0, 31'h20000, 31'h20000);
  endtask

  always @(posedge clk_i) begin
    contact_t e;
    if (start_i && !busy_o || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_ni && result_valid_o) begin
      if (expected_contacts.size() == 0) begin
        $error("result with no pending pair");
        errors++;
      end else begin
        e = expected_contacts.pop_front();
        if (hit_o !== e.hit) begin
          $error("hit exp %0d got %0d", e.hit, hit_o); errors++;
        end
        if (normal_x_o !== e.nx) begin
          $error("normal_x exp %0d got %0d", e.nx, normal_x_o); errors++;
        end
        if (normal_z_o !== e.nz) begin
          $error("normal_z exp %0d got %0d", e.nz, normal_z_o); errors++;
        end
        if (penetration_depth_o !== e.depth) begin
          $error("penetration_depth exp %0d got %0d", e.depth, penetration_depth_o);
          errors++;
        end
        if (world_contact_x_o !== e.wx) begin
          $error("world_contact_x exp %0d got %0d", e.wx, world_contact_x_o); errors++;
        end
        if (world_contact_z_o !== e.wz) begin
          $error("world_contact_z exp %0d got %0d", e.wz, world_contact_z_o); errors++;
        end
        if (circle_local_x_o !== e.cx) begin
          $error("circle_local_x exp %0d got %0d", e.cx, circle_local_x_o); errors++;
        end
        if (circle_local_z_o !== e.cz) begin
          $error("circle_local_z exp %0d got %0d", e.cz, circle_local_z_o); errors++;
        end
        if (box_local_x_o !== e.bx) begin
          $error("box_local_x exp %0d got %0d", e.bx, box_local_x_o); errors++;
        end
        if (box_local_z_o !== e.bz) begin
          $error("box_local_z exp %0d got %0d", e.bz, box_local_z_o); errors++;
        end
      end
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(350, 0);
    test_random(350, 67);
    test_quiet_pause();
    test_random(300, 21);
    test_random(300, 0);
    drain_results();
    repeat (LATENCY) @(negedge clk_i);
    if (errors == 0 && expected_contacts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== circle_box_contact_unit.f =====
design/cbc_pkg.sv
design/circle_box_contact_unit.sv
dv/tb_circle_box_contact_unit.sv
